FILE: hw/rtl/dsrl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsrl_pkg
// shared types, constants and hash round for the sketch rate limiter
// ----------------------------------------------------------------------------
package dsrl_pkg;

    localparam int unsigned SLOTS_DEFAULT = 1024;

    localparam logic [63:0] HK0 = 64'h736f6d6570736575;
    localparam logic [63:0] HK1 = 64'h6c7967656e657261;
    localparam logic [63:0] HK2 = 64'h646f72616e646f6d;
    localparam logic [63:0] HK3 = 64'h7465646279746573;
    localparam logic [63:0] FIN_XOR = 64'h00000000000000ff;

    localparam logic [31:0] PEAK_RESET   = 32'd100;
    localparam logic [31:0] PERIOD_RESET = 32'd1024;

    localparam int unsigned CFG_IDX_W = 2;

    typedef enum logic [1:0] {
        OP_HIT   = 2'd0,
        OP_CLEAR = 2'd1,
        OP_REKEY = 2'd2,
        OP_NOP   = 2'd3
    } opcode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PEAK     = 2'd0,
        CFG_PERIOD   = 2'd1,
        CFG_KEY_LOW  = 2'd2,
        CFG_KEY_HIGH = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic [63:0] v0;
        logic [63:0] v1;
        logic [63:0] v2;
        logic [63:0] v3;
    } hash_state_t;

    // hash result handed to the counter engine
    typedef struct packed {
        opcode_t     op;
        logic [63:0] h1;
        logic [63:0] h2;
    } hash_res_t;

    function automatic logic [63:0] rotl(input logic [63:0] x, input int unsigned r);
        rotl = (x << r) | (x >> (64 - r));
    endfunction

    function automatic hash_state_t mix_round(input hash_state_t s);
        hash_state_t t;
        t = s;
        t.v0 = t.v0 + t.v1; t.v1 = rotl(t.v1, 13); t.v1 = t.v1 ^ t.v0;
        t.v0 = rotl(t.v0, 32);
        t.v2 = t.v2 + t.v3; t.v3 = rotl(t.v3, 16); t.v3 = t.v3 ^ t.v2;
        t.v0 = t.v0 + t.v3; t.v3 = rotl(t.v3, 21); t.v3 = t.v3 ^ t.v0;
        t.v2 = t.v2 + t.v1; t.v1 = rotl(t.v1, 17); t.v1 = t.v1 ^ t.v2;
        t.v2 = rotl(t.v2, 32);
        mix_round = t;
    endfunction

endpackage

FILE: hw/rtl/dsrl_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsrl_in_if / dsrl_out_if
// valid/ready channels for requests and verdicts
// ----------------------------------------------------------------------------
interface dsrl_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  opcode;
    logic [63:0] addr_low;
    logic [63:0] addr_high;
    modport source (output valid, output opcode, output addr_low, output addr_high,
                    input ready);
    modport sink (input valid, input opcode, input addr_low, input addr_high,
                  output ready);
endinterface

interface dsrl_out_if;
    logic valid;
    logic ready;
    logic limited;
    modport source (output valid, output limited, input ready);
    modport sink (input valid, input limited, output ready);
endinterface

FILE: hw/rtl/decaying_sketch_rate_limiter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// decaying_sketch_rate_limiter
// count-min sketch rate limiter with sweeping decay and keyed hash
// ----------------------------------------------------------------------------
//  channel   dir  signals                          meaning
//  req       in   valid ready opcode addr_*        hit / clear / rekey request
//  rsp       out  valid ready limited              one verdict per request
//  cfg       in   cfg_we cfg_index cfg_data        register writes
//
//  a hit runs 6 hash rounds, then decay and two counter read-modify-writes
//  through the counter memory
//  clear and rekey end when the one-round-per-cycle hash unit is done
//  after reset a clearing pass zeroes the counter memory
//  a waiting verdict does not stall a new transfer; a second finished verdict
//  parks in a spare register and blocks new transfers until the first leaves
// ----------------------------------------------------------------------------
module decaying_sketch_rate_limiter #(
    parameter int unsigned SLOTS = dsrl_pkg::SLOTS_DEFAULT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    dsrl_in_if.sink                          req,
    dsrl_out_if.source                       rsp,
    input  logic                             cfg_we,
    input  logic [dsrl_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [63:0]                      cfg_data
);
    import dsrl_pkg::*;

    // configuration and active key
    logic [31:0] peak_reg, period_reg;
    logic [63:0] akey0_reg, akey1_reg;

    logic        busy_reg, busy_next;
    logic        ovalid_reg, ovalid_next;
    logic        olim_reg, olim_next;
    logic        pend_reg, pend_next;
    logic        plim_reg, plim_next;
    logic        accept;
    logic        hash_done, cnt_start, cnt_done, cnt_lim, clr_busy;
    hash_res_t   hres;

    // one item in flight; a verdict may wait at the output while the next runs
    assign req.ready = !busy_reg && !clr_busy && !pend_reg;
    assign accept    = req.valid && req.ready;

    dsrl_hash u_hash (
        .clk   (clk),
        .rst_n (rst_n),
        .start (accept),
        .op    (opcode_t'(req.opcode)),
        .lo    (req.addr_low),
        .hi    (req.addr_high),
        .key0  (akey0_reg),
        .key1  (akey1_reg),
        .done  (hash_done),
        .res   (hres)
    );

    assign cnt_start = hash_done;

    dsrl_counters #(.SLOTS(SLOTS)) u_cnt (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (cnt_start),
        .req          (hres),
        .peak         (peak_reg),
        .decay_period (period_reg),
        .clr_busy     (clr_busy),
        .done         (cnt_done),
        .limited      (cnt_lim)
    );

    always_comb
    begin
        busy_next   = busy_reg;
        ovalid_next = ovalid_reg;
        olim_next   = olim_reg;
        pend_next   = pend_reg;
        plim_next   = plim_reg;
        // output transfer: the parked verdict, if any, moves up
        if (rsp.valid && rsp.ready)
        begin
            ovalid_next = pend_reg;
            olim_next   = plim_reg;
            pend_next   = 1'b0;
        end
        if (accept)
            busy_next = 1'b1;
        if (cnt_done)
        begin
            busy_next = 1'b0;
            if (ovalid_next)
            begin
                pend_next = 1'b1;
                plim_next = cnt_lim;
            end
            else
            begin
                ovalid_next = 1'b1;
                olim_next   = cnt_lim;
            end
        end
    end

    assign rsp.valid   = ovalid_reg;
    assign rsp.limited = olim_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg   <= 1'b0;
            ovalid_reg <= 1'b0;
            olim_reg   <= 1'b0;
            pend_reg   <= 1'b0;
            plim_reg   <= 1'b0;
            peak_reg   <= PEAK_RESET;
            period_reg <= PERIOD_RESET;
            akey0_reg  <= '0;
            akey1_reg  <= '0;
        end
        else
        begin
            busy_reg   <= busy_next;
            ovalid_reg <= ovalid_next;
            olim_reg   <= olim_next;
            pend_reg   <= pend_next;
            plim_reg   <= plim_next;
            if (cfg_we)
            begin
                case (cfg_idx_t'(cfg_index))
                    CFG_PEAK:     peak_reg   <= cfg_data[31:0];
                    CFG_PERIOD:   period_reg <= cfg_data[31:0];
                    CFG_KEY_LOW:  akey0_reg  <= cfg_data;
                    CFG_KEY_HIGH: akey1_reg  <= cfg_data;
                    default:      ;
                endcase
            end
            // rekey takes the two hash words of the zero address
            if (hash_done && hres.op == OP_REKEY)
            begin
                akey0_reg <= hres.h1;
                akey1_reg <= hres.h2;
            end
        end
    end

    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_done |-> busy_reg) else $error("completion without item");
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> !req.ready) else $error("accept while busy");
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_done |-> !pend_reg) else $error("verdict overwritten");
    a_pend_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> ovalid_reg) else $error("parked verdict with empty output");

endmodule

FILE: hw/rtl/dsrl_hash.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsrl_hash
// iterative keyed hash, one mix round per cycle
// ----------------------------------------------------------------------------
module dsrl_hash (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  dsrl_pkg::opcode_t  op,
    input  logic [63:0]        lo,
    input  logic [63:0]        hi,
    input  logic [63:0]        key0,
    input  logic [63:0]        key1,
    output logic               done,
    output dsrl_pkg::hash_res_t res
);
    import dsrl_pkg::*;

    // steps: 0 absorb lo, 1 absorb hi, 2..4 final rounds, 5 extra round
    logic        busy_reg, busy_next;
    logic [2:0]  step_reg, step_next;
    hash_state_t s_reg, s_next;
    logic [63:0] lo_reg, hi_reg, h1_reg, h1_next;
    opcode_t     op_reg;
    hash_state_t pre, post;

    always_comb
    begin
        pre = s_reg;
        if (step_reg == 3'd0)
            pre.v3 = s_reg.v3 ^ lo_reg;
        else if (step_reg == 3'd1)
            pre.v3 = s_reg.v3 ^ hi_reg;
        post = mix_round(pre);
        if (step_reg == 3'd0)
            post.v0 = post.v0 ^ lo_reg;
        else if (step_reg == 3'd1)
        begin
            post.v0 = post.v0 ^ hi_reg;
            post.v2 = post.v2 ^ FIN_XOR;
        end
    end

    always_comb
    begin
        busy_next = busy_reg;
        step_next = step_reg;
        s_next    = s_reg;
        h1_next   = h1_reg;
        done      = 1'b0;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = 3'd0;
            s_next.v0 = key0;
            s_next.v1 = key1;
            s_next.v2 = HK0 ^ HK1 ^ key0;
            s_next.v3 = HK2 ^ HK3 ^ key1;
        end
        else if (busy_reg)
        begin
            s_next    = post;
            step_next = step_reg + 3'd1;
            if (step_reg == 3'd4)
                h1_next = post.v0 ^ post.v1 ^ post.v2 ^ post.v3;
            if (step_reg == 3'd5)
            begin
                busy_next = 1'b0;
                done      = 1'b1;
            end
        end
    end

    assign res.op = op_reg;
    assign res.h1 = h1_reg;
    assign res.h2 = post.v0 ^ post.v1 ^ post.v2 ^ post.v3;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= 3'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s_reg  <= s_next;
        h1_reg <= h1_next;
        if (start)
        begin
            op_reg <= op;
            lo_reg <= (op == OP_REKEY) ? 64'd0 : lo;
            hi_reg <= (op == OP_REKEY) ? 64'd0 : hi;
        end
    end

    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy_reg) else $error("done without busy");
    a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy_reg) else $error("start while busy");
    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> step_reg <= 3'd5) else $error("step overrun");

endmodule

FILE: hw/rtl/dsrl_counters.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsrl_counters
// counter memory with decay sweep, read-modify-write of two slots, clear of one
// ----------------------------------------------------------------------------
module dsrl_counters #(
    parameter int unsigned SLOTS = dsrl_pkg::SLOTS_DEFAULT
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  dsrl_pkg::hash_res_t req,
    input  logic [31:0]         peak,
    input  logic [31:0]         decay_period,
    output logic                clr_busy,
    output logic                done,
    output logic                limited
);
    import dsrl_pkg::*;

    localparam int unsigned AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam logic [AW:0] SLOTS_W = AW'(0) | (AW+1)'(SLOTS);
    localparam logic [31:0] SLOTS_32 = 32'(SLOTS);
    localparam logic [63:0] MASK = 64'(SLOTS - 1);

    typedef enum logic [6:0] {
        S_CLR  = 7'b0000001,
        S_IDLE = 7'b0000010,
        S_DRD  = 7'b0000100,
        S_ARD  = 7'b0001000,
        S_AWR  = 7'b0010000,
        S_BRD  = 7'b0100000,
        S_BWR  = 7'b1000000
    } st_t;

    st_t st_reg, st_next;
    logic [31:0] mem [SLOTS];
    logic [31:0] rd_reg;
    logic [AW-1:0] raddr, waddr;
    logic        we;
    logic [31:0] wdata;
    logic [AW:0] clr_reg, clr_next;
    logic [31:0] pos_reg, pos_next;
    logic [AW-1:0] a_reg, b_reg;
    logic        lim_reg, lim_next;
    logic [31:0] period;
    logic [32:0] pos_inc;

    always_comb
    begin
        period   = (decay_period < SLOTS_32) ? SLOTS_32 : decay_period;
        pos_inc  = {1'b0, pos_reg} + 33'd1;
    end

    always_comb
    begin
        st_next  = st_reg;
        clr_next = clr_reg;
        pos_next = pos_reg;
        lim_next = lim_reg;
        raddr    = '0;
        waddr    = '0;
        we       = 1'b0;
        wdata    = '0;
        done     = 1'b0;
        case (st_reg)
            S_CLR:
            begin
                we       = 1'b1;
                waddr    = clr_reg[AW-1:0];
                clr_next = clr_reg + 1'b1;
                if (clr_next == SLOTS_W)
                    st_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (start)
                begin
                    case (req.op)
                        OP_HIT:
                        begin
                            raddr   = pos_reg[AW-1:0];
                            st_next = S_DRD;
                        end
                        OP_CLEAR:
                        begin
                            we    = 1'b1;
                            waddr = AW'(req.h1 & MASK);
                            done  = 1'b1;
                        end
                        default:
                            done = 1'b1;
                    endcase
                end
            end
            S_DRD:
            begin
                // halve the slot under the sweep pointer, then advance
                if (pos_reg < SLOTS_32)
                begin
                    we    = 1'b1;
                    waddr = pos_reg[AW-1:0];
                    wdata = rd_reg >> 1;
                end
                pos_next = ({1'b0, period} <= pos_inc) ? 32'd0 : pos_inc[31:0];
                raddr    = a_reg;
                st_next  = S_ARD;
            end
            S_ARD:
            begin
                st_next = S_AWR;
                raddr   = a_reg;
            end
            S_AWR:
            begin
                if (rd_reg < peak)
                begin
                    we       = 1'b1;
                    waddr    = a_reg;
                    wdata    = rd_reg + 32'd1;
                    lim_next = 1'b0;
                end
                else
                    lim_next = 1'b1;
                st_next = S_BRD;
            end
            S_BRD:
            begin
                raddr   = b_reg;
                st_next = S_BWR;
            end
            S_BWR:
            begin
                if (rd_reg < peak)
                begin
                    we       = 1'b1;
                    waddr    = b_reg;
                    wdata    = rd_reg + 32'd1;
                    lim_next = 1'b0;
                end
                done    = 1'b1;
                st_next = S_IDLE;
            end
            default:
                st_next = S_IDLE;
        endcase
    end

    assign clr_busy = (st_reg == S_CLR);
    assign limited  = (st_reg == S_BWR) ? ((rd_reg < peak) ? 1'b0 : lim_reg) : 1'b0;

    // synchronous memory, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rd_reg <= mem[raddr];
    end

    always_ff @(posedge clk)
    begin
        if (st_reg == S_IDLE && start)
        begin
            a_reg <= AW'(req.h1 & MASK);
            b_reg <= AW'(req.h2 & MASK);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg  <= S_CLR;
            clr_reg <= '0;
            pos_reg <= '0;
            lim_reg <= 1'b0;
        end
        else
        begin
            st_reg  <= st_next;
            clr_reg <= clr_next;
            pos_reg <= pos_next;
            lim_reg <= lim_next;
        end
    end

    a_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(st_reg)) else $error("state not one-hot");
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> st_reg == S_IDLE) else $error("start while busy");
    a_lim_hit: assert property (@(posedge clk) disable iff (!rst_n)
        limited |-> done) else $error("limited outside completion");

endmodule
